### design/stp_pkg.sv
// stp_pkg: shared constants, types and helpers of the stereographic projector
// used by every design file through scoped names; depends on nothing
`default_nettype none
package stp_pkg;

  localparam int IN_FRAC_BITS  = 30;
  localparam int OUT_FRAC_BITS = 24;

  localparam int WORD_W    = 32;
  localparam int PROD_W    = 64;
  localparam int MAG_W     = PROD_W - 1;
  localparam int DEN_W     = 64;
  localparam int ROOT_W    = 31;
  localparam int QUO_W     = 33;
  localparam int PRE_SHIFT = QUO_W - OUT_FRAC_BITS - 2;
  localparam int DIV_STEPS = QUO_W;
  localparam int ROOT_STEPS = PROD_W / 2;

  localparam logic signed [WORD_W-1:0] ONE    = WORD_W'(1) << IN_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ONE_SQ = PROD_W'(1) << (2 * IN_FRAC_BITS);
  localparam logic [PROD_W-1:0] ROOT_BIT0     = PROD_W'(1) << (PROD_W - 2);

  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_CENTER_Z = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_UNDEF = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] cx;
    logic signed [WORD_W-1:0] cy;
    logic signed [WORD_W-1:0] cz;
    logic [WORD_W-1:0]        qs;
    logic [ROOT_W-1:0]        root;
    logic                     q_zero;
  } center_t;

  typedef struct packed {
    logic             undef;
    logic             sign_e;
    logic             sign_n;
    logic [MAG_W-1:0] mag_e;
    logic [MAG_W-1:0] mag_n;
    logic [DEN_W-1:0] den;
  } front_t;

  typedef struct packed {
    logic                 undef;
    logic                 sign_e;
    logic                 sign_n;
    logic                 sat_e;
    logic                 sat_n;
    logic [DEN_W-1:0]     den;
    logic [DEN_W-1:0]     rem_e;
    logic [DEN_W-1:0]     rem_n;
    logic [PRE_SHIFT-1:0] low_e;
    logic [PRE_SHIFT-1:0] low_n;
    logic [QUO_W-1:0]     q_e;
    logic [QUO_W-1:0]     q_n;
  } div_t;

  function automatic logic signed [WORD_W-1:0] clamp_one(input logic signed [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > ONE) begin
      r = ONE;
    end else if (v < -ONE) begin
      r = -ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/stp_center.sv
// stp_center: centre registers, config write port and the centre-derived terms
// (radial square, its integer square root); depends on stp_pkg
`default_nettype none
module stp_center (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [stp_pkg::WORD_W-1:0]  cfg_data,
  output stp_pkg::center_t            center,
  output logic                        busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_ROOT = 2'd3;
  localparam int CNT_W = $clog2(stp_pkg::ROOT_STEPS);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(stp_pkg::ROOT_STEPS - 1);

  logic [1:0]                        state;
  logic [CNT_W-1:0]                  cnt;
  logic signed [stp_pkg::PROD_W-1:0] cxx;
  logic signed [stp_pkg::PROD_W-1:0] cyy;
  logic [stp_pkg::PROD_W-1:0]        rad;
  logic [stp_pkg::PROD_W-1:0]        res;
  logic [stp_pkg::PROD_W-1:0]        bitv;
  logic [stp_pkg::PROD_W-1:0]        q_sum;
  logic [stp_pkg::PROD_W-1:0]        sum_rb;
  logic                              take;
  logic [stp_pkg::PROD_W-1:0]        rad_next;
  logic [stp_pkg::PROD_W-1:0]        res_next;

  assign q_sum    = stp_pkg::PROD_W'(cxx + cyy);
  assign sum_rb   = res + bitv;
  assign take     = rad >= sum_rb;
  assign rad_next = take ? rad - sum_rb : rad;
  assign res_next = take ? (res >> 1) + bitv : res >> 1;
  assign busy     = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      center.cx     <= stp_pkg::ONE;
      center.cy     <= '0;
      center.cz     <= '0;
      center.qs     <= stp_pkg::WORD_W'(stp_pkg::ONE);
      center.root   <= stp_pkg::ROOT_W'(stp_pkg::ONE);
      center.q_zero <= 1'b0;
      state         <= ST_IDLE;
      cnt           <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        stp_pkg::CFG_CENTER_X: center.cx <= stp_pkg::clamp_one(cfg_data);
        stp_pkg::CFG_CENTER_Y: center.cy <= stp_pkg::clamp_one(cfg_data);
        stp_pkg::CFG_CENTER_Z: center.cz <= stp_pkg::clamp_one(cfg_data);
        default: ;
      endcase
      state <= ST_MUL;
    end else begin
      case (state)
        ST_MUL: state <= ST_SUM;
        ST_SUM: begin
          center.qs     <= stp_pkg::WORD_W'(q_sum >> stp_pkg::IN_FRAC_BITS);
          center.q_zero <= q_sum == '0;
          cnt           <= '0;
          state         <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROOT_LAST) begin
            center.root <= stp_pkg::ROOT_W'(res_next);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      cxx <= center.cx * center.cx;
      cyy <= center.cy * center.cy;
    end
    if (state == ST_SUM) begin
      rad  <= q_sum;
      res  <= '0;
      bitv <= stp_pkg::ROOT_BIT0;
    end else if (state == ST_ROOT) begin
      rad  <= rad_next;
      res  <= res_next;
      bitv <= bitv >> 2;
    end
  end

endmodule
`default_nettype wire

### design/stp_front.sv
// stp_front: six-stage front end, clamp, dot products, denominator and numerator
// magnitudes; depends on stp_pkg and the centre terms from stp_center
`default_nettype none
module stp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  output logic                               ready,
  input  logic signed [stp_pkg::WORD_W-1:0]  point_x,
  input  logic signed [stp_pkg::WORD_W-1:0]  point_y,
  input  logic signed [stp_pkg::WORD_W-1:0]  point_z,
  input  stp_pkg::center_t                   center,
  input  logic                               down_ready,
  output logic                               out_valid,
  output stp_pkg::front_t                    out_data
);

  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;

  logic signed [stp_pkg::WORD_W-1:0] p1x, p1y, p1z, p2z, p3z;
  logic signed [stp_pkg::PROD_W-1:0] mxx, myy, mzz, mxy, myx;
  logic signed [stp_pkg::WORD_W:0]   hs3;
  logic signed [stp_pkg::WORD_W+1:0] ds3;
  logic signed [stp_pkg::PROD_W-1:0] ae3, ae4, ae5, an1_4, an2_4, an5;
  logic [stp_pkg::DEN_W-1:0]         den4, den5;
  logic                              undef4, undef5;
  logic signed [stp_pkg::PROD_W-1:0] h, d;

  assign r6 = !v6 || down_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign ready = r1;
  assign out_valid = v6;

  assign h = mxx + myy;
  assign d = stp_pkg::ONE_SQ + h + mzz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (r1) v1 <= take;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      p1x <= stp_pkg::clamp_one(point_x);
      p1y <= stp_pkg::clamp_one(point_y);
      p1z <= stp_pkg::clamp_one(point_z);
    end
    if (r2) begin
      mxx <= center.cx * p1x;
      myy <= center.cy * p1y;
      mzz <= center.cz * p1z;
      mxy <= center.cx * p1y;
      myx <= center.cy * p1x;
      p2z <= p1z;
    end
    if (r3) begin
      hs3 <= (stp_pkg::WORD_W+1)'(h >>> stp_pkg::IN_FRAC_BITS);
      ds3 <= (stp_pkg::WORD_W+2)'(d >>> stp_pkg::IN_FRAC_BITS);
      ae3 <= mxy - myx;
      p3z <= p2z;
    end
    if (r4) begin
      undef4 <= (ds3 <= 0) || center.q_zero;
      den4   <= stp_pkg::DEN_W'(center.root) * stp_pkg::DEN_W'(ds3[stp_pkg::WORD_W:0]);
      an1_4  <= $signed({1'b0, center.qs}) * p3z;
      an2_4  <= center.cz * hs3;
      ae4    <= ae3;
    end
    if (r5) begin
      undef5 <= undef4;
      den5   <= den4;
      ae5    <= ae4;
      an5    <= an1_4 - an2_4;
    end
    if (r6) begin
      out_data.undef  <= undef5;
      out_data.den    <= den5;
      out_data.sign_e <= ae5[stp_pkg::PROD_W-1];
      out_data.sign_n <= an5[stp_pkg::PROD_W-1];
      out_data.mag_e  <= stp_pkg::MAG_W'(ae5[stp_pkg::PROD_W-1] ? -ae5 : ae5);
      out_data.mag_n  <= stp_pkg::MAG_W'(an5[stp_pkg::PROD_W-1] ? -an5 : an5);
    end
  end

endmodule
`default_nettype wire

### design/stp_divider.sv
// stp_divider: pipelined restoring divider, one quotient bit per stage for both
// plane coordinates; depends on stp_pkg and takes words from stp_front
`default_nettype none
module stp_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  output logic              ready,
  input  stp_pkg::front_t   din,
  input  logic              down_ready,
  output logic              out_valid,
  output stp_pkg::div_t     dout
);

  localparam int N = stp_pkg::DIV_STEPS;

  stp_pkg::div_t st [0:N];
  logic          v   [0:N];
  logic          rdy [0:N];
  stp_pkg::div_t first;

  function automatic stp_pkg::div_t step(input stp_pkg::div_t s);
    stp_pkg::div_t o;
    logic [stp_pkg::DEN_W:0] te;
    logic [stp_pkg::DEN_W:0] tn;
    logic [stp_pkg::DEN_W:0] dd;
    o  = s;
    dd = {1'b0, s.den};
    te = {s.rem_e, s.low_e[stp_pkg::PRE_SHIFT-1]};
    tn = {s.rem_n, s.low_n[stp_pkg::PRE_SHIFT-1]};
    o.low_e = s.low_e << 1;
    o.low_n = s.low_n << 1;
    if (te >= dd) begin
      o.rem_e = stp_pkg::DEN_W'(te - dd);
      o.q_e   = {s.q_e[stp_pkg::QUO_W-2:0], 1'b1};
    end else begin
      o.rem_e = stp_pkg::DEN_W'(te);
      o.q_e   = {s.q_e[stp_pkg::QUO_W-2:0], 1'b0};
    end
    if (tn >= dd) begin
      o.rem_n = stp_pkg::DEN_W'(tn - dd);
      o.q_n   = {s.q_n[stp_pkg::QUO_W-2:0], 1'b1};
    end else begin
      o.rem_n = stp_pkg::DEN_W'(tn);
      o.q_n   = {s.q_n[stp_pkg::QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    first.undef  = din.undef;
    first.sign_e = din.sign_e;
    first.sign_n = din.sign_n;
    first.den    = din.den;
    first.rem_e  = stp_pkg::DEN_W'(din.mag_e >> stp_pkg::PRE_SHIFT);
    first.rem_n  = stp_pkg::DEN_W'(din.mag_n >> stp_pkg::PRE_SHIFT);
    first.sat_e  = stp_pkg::DEN_W'(din.mag_e >> stp_pkg::PRE_SHIFT) >= din.den;
    first.sat_n  = stp_pkg::DEN_W'(din.mag_n >> stp_pkg::PRE_SHIFT) >= din.den;
    first.low_e  = din.mag_e[stp_pkg::PRE_SHIFT-1:0];
    first.low_n  = din.mag_n[stp_pkg::PRE_SHIFT-1:0];
    first.q_e    = '0;
    first.q_n    = '0;
  end

  always_comb begin
    rdy[N] = !v[N] || down_ready;
    for (int j = N - 1; j >= 0; j--) begin
      rdy[j] = !v[j] || rdy[j+1];
    end
  end

  assign ready     = rdy[0];
  assign out_valid = v[N];
  assign dout      = st[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= N; j++) begin
        v[j] <= 1'b0;
      end
    end else begin
      if (rdy[0]) v[0] <= take;
      for (int j = 1; j <= N; j++) begin
        if (rdy[j]) v[j] <= v[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) st[0] <= first;
    for (int j = 1; j <= N; j++) begin
      if (rdy[j]) st[j] <= step(st[j-1]);
    end
  end

endmodule
`default_nettype wire

### design/stereographic_projection.sv
// Oblique stereographic projector: one point word per cycle unless out_ready or a config
// update holds it off; 6 front-end stages, 34 divider stages, output register. The
// latency is set mostly by the divider, one quotient bit in each of its 33 step stages.
// After each config write the input is held off while the centre's radial root is
// worked out bit by bit; status 0 ok, 1 saturated, 2 undefined (antipode or polar centre).
// depends on stp_pkg, stp_center, stp_front and stp_divider
`default_nettype none
module stereographic_projection (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [stp_pkg::WORD_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [stp_pkg::WORD_W-1:0]  point_x,
  input  logic signed [stp_pkg::WORD_W-1:0]  point_y,
  input  logic signed [stp_pkg::WORD_W-1:0]  point_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [stp_pkg::WORD_W-1:0]  east,
  output logic signed [stp_pkg::WORD_W-1:0]  north,
  output logic [1:0]                         status
);

  stp_pkg::center_t center;
  stp_pkg::front_t  front_data;
  stp_pkg::div_t    div_data;
  logic             busy;
  logic             front_ready;
  logic             front_valid;
  logic             div_ready;
  logic             div_valid;
  logic             out_rdy;
  logic [stp_pkg::WORD_W:0] lane_e;
  logic [stp_pkg::WORD_W:0] lane_n;

  function automatic logic [stp_pkg::WORD_W:0] round_sat(input logic [stp_pkg::QUO_W-1:0] q,
                                                         input logic sat, input logic neg);
    logic [stp_pkg::QUO_W:0] qr;
    logic [stp_pkg::QUO_W:0] cap;
    logic [stp_pkg::QUO_W:0] val;
    logic                    over;
    qr   = ({1'b0, q} + 1'b1) >> 1;
    cap  = neg ? (stp_pkg::QUO_W+1)'(1) << (stp_pkg::WORD_W - 1)
               : ((stp_pkg::QUO_W+1)'(1) << (stp_pkg::WORD_W - 1)) - 1'b1;
    over = sat || (qr > cap);
    val  = over ? cap : qr;
    val  = neg ? -val : val;
    return {over, val[stp_pkg::WORD_W-1:0]};
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = front_ready && !busy && !cfg_valid;
  assign out_rdy   = !out_valid || out_ready;
  assign lane_e    = round_sat(div_data.q_e, div_data.sat_e, div_data.sign_e);
  assign lane_n    = round_sat(div_data.q_n, div_data.sat_n, div_data.sign_n);

  stp_center u_center (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .center    (center),
    .busy      (busy)
  );

  stp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (in_valid && in_ready),
    .ready      (front_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .center     (center),
    .down_ready (div_ready),
    .out_valid  (front_valid),
    .out_data   (front_data)
  );

  stp_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .take       (front_valid),
    .ready      (div_ready),
    .din        (front_data),
    .down_ready (out_rdy),
    .out_valid  (div_valid),
    .dout       (div_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_rdy) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      if (div_data.undef) begin
        east   <= '0;
        north  <= '0;
        status <= stp_pkg::STATUS_UNDEF;
      end else begin
        east   <= lane_e[stp_pkg::WORD_W-1:0];
        north  <= lane_n[stp_pkg::WORD_W-1:0];
        status <= (lane_e[stp_pkg::WORD_W] || lane_n[stp_pkg::WORD_W]) ?
                  stp_pkg::STATUS_SAT : stp_pkg::STATUS_OK;
      end
    end
  end

`ifndef SYNTH
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == stp_pkg::STATUS_OK || status == stp_pkg::STATUS_SAT ||
                   status == stp_pkg::STATUS_UNDEF))
    else $error("bad status code");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == stp_pkg::STATUS_UNDEF) |-> (east == 0 && north == 0))
    else $error("undefined word with nonzero coordinates");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == stp_pkg::STATUS_SAT) |->
      (east == 32'sh7fffffff || east == 32'sh80000000 ||
       north == 32'sh7fffffff || north == 32'sh80000000))
    else $error("saturated word without an extreme coordinate");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("input taken while centre terms are recomputed");
`endif

endmodule
`default_nettype wire
